FILE: src/hsfd_pkg.sv
// hsfd_pkg: shared widths, frame constants, the frame record type and the
// field scaling saturation used by the frame decoder.
// No dependencies.
`default_nettype none

package hsfd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned RawW        = 12;
  localparam int unsigned GainW       = 16;
  localparam int unsigned FieldW      = 18;
  localparam int unsigned IndexW      = 2;
  localparam int unsigned PosW        = 3;
  localparam int unsigned ShiftBits   = 8;
  localparam int unsigned ProdW       = RawW + GainW + 1;
  localparam int unsigned QuotW       = ProdW - ShiftBits;

  localparam int unsigned SensorCount = 3;
  localparam int unsigned FrameBytes  = 7;

  // Byte positions inside a frame
  localparam logic [PosW-1:0] PosHighX   = PosW'(0);
  localparam logic [PosW-1:0] PosHighY   = PosW'(1);
  localparam logic [PosW-1:0] PosHighZ   = PosW'(2);
  localparam logic [PosW-1:0] PosXyLow   = PosW'(4);
  localparam logic [PosW-1:0] PosZLow    = PosW'(5);
  localparam logic [PosW-1:0] PosFinal   = PosW'(FrameBytes - 1);

  localparam logic [IndexW-1:0] LastSensor = IndexW'(SensorCount - 1);

  localparam logic [GainW-1:0] GainReset = GainW'(8511);

  localparam logic signed [FieldW-1:0] FieldMax = {1'b0, {(FieldW-1){1'b1}}};
  localparam logic signed [FieldW-1:0] FieldMin = {1'b1, {(FieldW-1){1'b0}}};

  typedef struct packed {
    logic [IndexW-1:0]      sensor_index;
    logic signed [RawW-1:0] raw_x;
    logic signed [RawW-1:0] raw_y;
    logic signed [RawW-1:0] raw_z;
    logic                   frame_ok;
    logic                   group_ok;
    logic                   last;
  } frame_rec_t;

  // floor(p / 256), saturated to the field range
  function automatic logic signed [FieldW-1:0] sat_field(
    input logic signed [ProdW-1:0] p
  );
    logic [QuotW-1:0]        q;
    logic [QuotW-FieldW:0]   top_bits;
    logic signed [FieldW-1:0] r;
    q        = p[ProdW-1:ShiftBits];
    top_bits = q[QuotW-1:FieldW-1];
    if ((&top_bits) || !(|top_bits)) begin
      r = q[FieldW-1:0];
    end else if (q[QuotW-1]) begin
      r = FieldMin;
    end else begin
      r = FieldMax;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/hsfd_front.sv
// hsfd_front: byte-level frame parser. Accumulates parity, captures the
// value bytes and pushes one frame record per finished or aborted frame.
// Depends on hsfd_pkg.
`default_nettype none

module hsfd_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [hsfd_pkg::ByteW-1:0]     rx_byte_i,
  input  wire                           short_read_i,
  input  wire                           q_full_i,
  output logic                          push_o,
  output hsfd_pkg::frame_rec_t          rec_o
);

  logic [hsfd_pkg::PosW-1:0]   pos_q, pos_d;
  logic [hsfd_pkg::ByteW-1:0]  par_q, par_d;
  logic [hsfd_pkg::ByteW-1:0]  hi_q [3];
  logic [hsfd_pkg::ByteW-1:0]  xy_q;
  logic [3:0]                  zl_q;
  logic [hsfd_pkg::IndexW-1:0] cnt_q, cnt_d;
  logic                        gok_q, gok_d;

  logic accept;
  logic term;
  logic ok;
  logic is_last;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign term       = short_read_i || (pos_q >= hsfd_pkg::PosFinal);
  assign ok         = !short_read_i && (^(par_q ^ {rx_byte_i[7], 7'b0}));
  assign is_last    = cnt_q >= hsfd_pkg::LastSensor;
  assign push_o     = accept && term;

  always_comb begin
    rec_o.sensor_index = cnt_q;
    rec_o.raw_x        = ok ? {hi_q[0], xy_q[7:4]} : '0;
    rec_o.raw_y        = ok ? {hi_q[1], xy_q[3:0]} : '0;
    rec_o.raw_z        = ok ? {hi_q[2], zl_q} : '0;
    rec_o.frame_ok     = ok;
    rec_o.group_ok     = is_last && ok && gok_q;
    rec_o.last         = is_last;
  end

  always_comb begin
    pos_d = pos_q;
    par_d = par_q;
    cnt_d = cnt_q;
    gok_d = gok_q;
    if (accept) begin
      if (term) begin
        pos_d = '0;
        par_d = '0;
        if (is_last) begin
          cnt_d = '0;
          gok_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
          gok_d = gok_q && ok;
        end
      end else begin
        pos_d = pos_q + 1'b1;
        par_d = par_q ^ rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      par_q <= '0;
      cnt_q <= '0;
      gok_q <= 1'b1;
    end else begin
      pos_q <= pos_d;
      par_q <= par_d;
      cnt_q <= cnt_d;
      gok_q <= gok_d;
    end
  end

  // Value bytes: captured only on body bytes, read only on a good frame
  always_ff @(posedge clk_i) begin
    if (accept && !term) begin
      case (pos_q)
        hsfd_pkg::PosHighX: hi_q[0] <= rx_byte_i;
        hsfd_pkg::PosHighY: hi_q[1] <= rx_byte_i;
        hsfd_pkg::PosHighZ: hi_q[2] <= rx_byte_i;
        hsfd_pkg::PosXyLow: xy_q    <= rx_byte_i;
        hsfd_pkg::PosZLow:  zl_q    <= rx_byte_i[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/hsfd_queue.sv
// hsfd_queue: small FIFO of frame records between parser and scaler.
// Depends on hsfd_pkg.
`default_nettype none

module hsfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  hsfd_pkg::frame_rec_t rec_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 empty_o,
  output hsfd_pkg::frame_rec_t rec_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  hsfd_pkg::frame_rec_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/hsfd_back.sv
// hsfd_back: scaling pipeline. Multiplies raw values by the gain, then
// floors, saturates and holds the result in the output register.
// Depends on hsfd_pkg.
`default_nettype none

module hsfd_back (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire  [hsfd_pkg::GainW-1:0]           gain_i,
  input  wire                                  q_empty_i,
  input  hsfd_pkg::frame_rec_t                 rec_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output hsfd_pkg::frame_rec_t                 out_rec_o,
  output logic signed [hsfd_pkg::FieldW-1:0]   field_x_o,
  output logic signed [hsfd_pkg::FieldW-1:0]   field_y_o,
  output logic signed [hsfd_pkg::FieldW-1:0]   field_z_o
);

  logic                                s1_valid_q;
  hsfd_pkg::frame_rec_t                s1_rec_q;
  logic signed [hsfd_pkg::ProdW-1:0]   px_q, py_q, pz_q;
  logic signed [hsfd_pkg::ProdW-1:0]   px_d, py_d, pz_d;
  logic signed [hsfd_pkg::GainW:0]     gain_s;

  logic                                out_valid_q;
  hsfd_pkg::frame_rec_t                out_rec_q;
  logic signed [hsfd_pkg::FieldW-1:0] fx_q, fy_q, fz_q;

  logic out_free, s1_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_free  = !s1_valid_q || out_free;
  assign pop_o    = !q_empty_i && s1_free;

  assign gain_s = $signed({1'b0, gain_i});
  assign px_d   = $signed(rec_i.raw_x) * gain_s;
  assign py_d   = $signed(rec_i.raw_y) * gain_s;
  assign pz_d   = $signed(rec_i.raw_z) * gain_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= pop_o;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_rec_q <= rec_i;
      px_q     <= px_d;
      py_q     <= py_d;
      pz_q     <= pz_d;
    end
    if (s1_valid_q && out_free) begin
      out_rec_q <= s1_rec_q;
      fx_q      <= hsfd_pkg::sat_field(px_q);
      fy_q      <= hsfd_pkg::sat_field(py_q);
      fz_q      <= hsfd_pkg::sat_field(pz_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;
  assign field_x_o   = fx_q;
  assign field_y_o   = fy_q;
  assign field_z_o   = fz_q;

endmodule

`default_nettype wire

FILE: src/hall_sensor_frame_decoder.sv
// hall_sensor_frame_decoder: top level of the magnetometer frame decoder.
// Depends on hsfd_pkg, hsfd_front, hsfd_queue and hsfd_back.
//
//   Channel  Direction  Handshake                 Word
//   -------  ---------  ------------------------  ---------------------------------
//   in       input      in_valid_i / in_stall_o   rx_byte_i, short_read_i
//   out      output     out_valid_o / out_stall_i sensor_index_o, raw_*_o,
//                                                 field_*_o, frame_ok_o,
//                                                 group_ok_o, last_o
//   cfg      input      cfg_valid_i / cfg_ready_o lsb_gain_i
//
// One input word per cycle while the queue is not full; the parser finishes a
// frame on its seventh byte or on a short read and queues one record. The
// scaler takes one record per cycle unless the output is held, through a
// multiply stage and a saturate stage.
// Reset clears the parser position, parity, sensor count, the queue and both
// pipeline stages and sets the group flag; the gain returns to 8511.
// A held output stalls the scaler, a full queue stalls the input.
`default_nettype none

module hall_sensor_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // byte input
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [7:0]                           rx_byte_i,
  input  wire                                  short_read_i,
  // results
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [1:0]                           sensor_index_o,
  output logic signed [11:0]                   raw_x_o,
  output logic signed [11:0]                   raw_y_o,
  output logic signed [11:0]                   raw_z_o,
  output logic signed [17:0]                   field_x_o,
  output logic signed [17:0]                   field_y_o,
  output logic signed [17:0]                   field_z_o,
  output logic                                 frame_ok_o,
  output logic                                 group_ok_o,
  output logic                                 last_o,
  // gain register
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [15:0]                          lsb_gain_i
);

  logic [hsfd_pkg::GainW-1:0] gain_q;

  logic                 push;
  logic                 pop;
  logic                 q_full;
  logic                 q_empty;
  hsfd_pkg::frame_rec_t front_rec;
  hsfd_pkg::frame_rec_t head_rec;
  hsfd_pkg::frame_rec_t out_rec;

  // Gain register: always writable; change only while idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= hsfd_pkg::GainReset;
    end else if (cfg_valid_i) begin
      gain_q <= lsb_gain_i;
    end
  end

  // Parse bytes, emit one record per frame
  hsfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .short_read_i(short_read_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (front_rec)
  );

  // Decouple parser from scaler
  hsfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (front_rec),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .rec_o  (head_rec)
  );

  // Scale and hold results
  hsfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gain_i     (gain_q),
    .q_empty_i  (q_empty),
    .rec_i      (head_rec),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rec_o  (out_rec),
    .field_x_o  (field_x_o),
    .field_y_o  (field_y_o),
    .field_z_o  (field_z_o)
  );

  assign sensor_index_o = out_rec.sensor_index;
  assign raw_x_o        = out_rec.raw_x;
  assign raw_y_o        = out_rec.raw_y;
  assign raw_z_o        = out_rec.raw_z;
  assign frame_ok_o     = out_rec.frame_ok;
  assign group_ok_o     = out_rec.group_ok;
  assign last_o         = out_rec.last;

endmodule

`default_nettype wire

FILE: tb/hall_sensor_frame_decoder_tb.sv
// Self-checking testbench for hall_sensor_frame_decoder: byte frames in, scaled
// X/Y/Z readings out, compared against an in-bench frame decoder model.
// Depends on hsfd_pkg and the hall_sensor_frame_decoder RTL only.
module hall_sensor_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Odd parity covers bytes 0..5 and only the top bit of the final byte.
  localparam logic [7:0] ParityBit     = 8'h80;
  // Words per random phase and the no-progress watchdog limit in cycles.
  localparam int         PhaseWords    = 180;
  localparam int         WatchdogLimit = 400;
  // Cycles to wait after the last reading before touching the gain or ending.
  localparam int         SettleCycles  = 12;

  // One decoded reading, laid out like the result port group.
  typedef struct packed {
    logic [1:0]          sensor;
    logic signed [11:0]  rx;
    logic signed [11:0]  ry;
    logic signed [11:0]  rz;
    logic signed [17:0]  fx;
    logic signed [17:0]  fy;
    logic signed [17:0]  fz;
    logic                ok;
    logic                grp;
    logic                last;
  } flux_word_t;

  // Directed stimulus row; pinned rows carry a hand-worked reading.
  typedef struct {
    logic [7:0] b;
    logic       s;
    bit         pinned;
    flux_word_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i     = 8'h00;
  logic        short_read_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [1:0]  sensor_index_o;
  logic signed [11:0] raw_x_o, raw_y_o, raw_z_o;
  logic signed [17:0] field_x_o, field_y_o, field_z_o;
  logic        frame_ok_o, group_ok_o, last_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] lsb_gain_i    = 16'h0000;

  hall_sensor_frame_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .short_read_i   (short_read_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sensor_index_o (sensor_index_o),
    .raw_x_o        (raw_x_o),
    .raw_y_o        (raw_y_o),
    .raw_z_o        (raw_z_o),
    .field_x_o      (field_x_o),
    .field_y_o      (field_y_o),
    .field_z_o      (field_z_o),
    .frame_ok_o     (frame_ok_o),
    .group_ok_o     (group_ok_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .lsb_gain_i     (lsb_gain_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Frame decoder model state: mirrors the parser and the gain register.
  // ---------------------------------------------------------------------------
  logic [15:0] gain_q        = hsfd_pkg::GainReset;
  logic [2:0]  pos_q         = '0;
  logic [7:0]  parity_q      = '0;
  logic [7:0]  high_byte [3] = '{default: '0};
  logic [7:0]  xy_low_q      = '0;
  logic [3:0]  z_low_q       = '0;
  logic [1:0]  sensor_q      = '0;
  logic        group_ok_q    = 1'b1;

  flux_word_t  due_readings [$];
  int          fails         = 0;
  int          words_sent    = 0;
  int          stuck_cycles  = 0;
  bit          steady_tail   = 1'b0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  // floor(raw * gain / 256), clamped to the 18-bit field range
  function automatic logic signed [17:0] scale_flux(input logic signed [11:0] raw);
    longint prod;
    prod = (longint'(raw) * longint'(gain_q)) >>> 8;
    if (prod > longint'(hsfd_pkg::FieldMax)) prod = longint'(hsfd_pkg::FieldMax);
    if (prod < longint'(hsfd_pkg::FieldMin)) prod = longint'(hsfd_pkg::FieldMin);
    return prod[17:0];
  endfunction

  // Advance the model by one word; return 1 when the word closes a frame.
  function automatic bit decode_word(input logic [7:0] b, input logic s,
                                     output flux_word_t r);
    bit ok;
    bit at_last;
    r = '0;
    if (!s) begin
      // Collect bytes until the final position; any stray position counts as final.
      if (pos_q < hsfd_pkg::PosFinal) begin
        parity_q = parity_q ^ b;
        case (pos_q)
          hsfd_pkg::PosHighX, hsfd_pkg::PosHighY, hsfd_pkg::PosHighZ:
            high_byte[pos_q[1:0]] = b;
          hsfd_pkg::PosXyLow: xy_low_q = b;
          hsfd_pkg::PosZLow:  z_low_q = b[3:0];
          default: ;
        endcase
        pos_q = pos_q + 3'd1;
        return 1'b0;
      end
      ok = ^(parity_q ^ (b & ParityBit));
    end else begin
      // Short read: drop the frame, report a failed reading right away.
      ok = 1'b0;
    end

    at_last  = sensor_q >= hsfd_pkg::LastSensor;
    r.sensor = sensor_q;
    r.ok     = ok;
    r.last   = at_last;
    r.grp    = at_last && ok && group_ok_q;
    // A failed frame reports zeros, never the previous sensor's values.
    if (ok) begin
      r.rx = {high_byte[0], xy_low_q[7:4]};
      r.ry = {high_byte[1], xy_low_q[3:0]};
      r.rz = {high_byte[2], z_low_q};
      r.fx = scale_flux(r.rx);
      r.fy = scale_flux(r.ry);
      r.fz = scale_flux(r.rz);
    end

    if (at_last) begin
      sensor_q   = '0;
      group_ok_q = 1'b1;
    end else begin
      sensor_q   = sensor_q + 2'd1;
      group_ok_q = group_ok_q && ok;
    end
    pos_q    = '0;
    parity_q = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: hold the word until accepted, then maybe drop valid for a burst.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input logic s, input bit pinned,
                           input flux_word_t want);
    flux_word_t calc;
    in_valid_i   <= 1'b1;
    rx_byte_i    <= b;
    short_read_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (decode_word(b, s, calc)) due_readings.push_back(pinned ? want : calc);
    if (!steady_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Mostly well-formed frames with random content, biased toward field extremes;
  // some carry a parity error, some are cut short at a random byte.
  task automatic send_frame();
    logic [7:0] fb [7];
    logic       p;
    int         cut;
    for (int i = 0; i < 7; i++) begin
      fb[i] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       fb[i] = 8'h00;
          1:       fb[i] = 8'hFF;
          2:       fb[i] = 8'h7F;
          default: fb[i] = 8'h80;
        endcase
      end
    end
    p = ^(fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4] ^ fb[5]);
    // Force the parity bit: good parity on most frames, a deliberate error on the rest.
    fb[6][7] = ($urandom_range(0, 6) != 0) ? ~p : p;
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 6) : 7;
    for (int i = 0; i < cut; i++) send_word(fb[i], 1'b0, 1'b0, '0);
    if (cut < 7) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  // Write the gain only once every reading has drained and the pipe has settled.
  task automatic load_gain(input logic [15:0] g);
    while (due_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    lsb_gain_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gain_q = g;
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows, gain at its reset value (8511).
  //   sensor 0: X = +2047, Y = -2048, Z = 0, good parity
  //   sensor 1: same bytes, parity error -> zeros
  //   sensor 2: short read at byte 3 -> zeros, last of the group
  //   sensor 0: short read at byte 0
  //   sensor 1: all ones, X = Y = Z = -1 (model-checked)
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [26] = '{
    '{8'h7F, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0}, '{8'hF0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b1, '{2'd0, 12'sd2047, 12'(-2048), 12'sd0,
                           18'sd68054, 18'(-68088), 18'sd0, 1'b1, 1'b0, 1'b0}},
    '{8'h7F, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0}, '{8'hF0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{2'd1, 12'sd0, 12'sd0, 12'sd0,
                           18'sd0, 18'sd0, 18'sd0, 1'b0, 1'b0, 1'b0}},
    '{8'h12, 1'b0, 1'b0, '0}, '{8'h34, 1'b0, 1'b0, '0}, '{8'h56, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{2'd2, 12'sd0, 12'sd0, 12'sd0,
                           18'sd0, 18'sd0, 18'sd0, 1'b0, 1'b0, 1'b1}},
    '{8'h00, 1'b1, 1'b1, '{2'd0, 12'sd0, 12'sd0, 12'sd0,
                           18'sd0, 18'sd0, 18'sd0, 1'b0, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}
  };

  // Main sequence: reset, directed rows, then random phases across gain settings.
  initial begin
    logic [15:0] gains [6];
    int          start;
    gains = '{16'd4256, 16'hFFFF, 16'h0000, 16'h0001,
              16'($urandom_range(0, 65535)), 16'd8511};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].b, dir_rows[i].s,
                                    dir_rows[i].pinned, dir_rows[i].want);

    // First random phase runs at the reset gain, then sweep the gain.
    for (int ph = 0; ph <= 6; ph++) begin
      if (ph > 0) begin
        in_valid_i <= 1'b0;
        load_gain(gains[ph-1]);
        // Run the last phase at full rate: no gaps, no stalls.
        if (ph == 6) steady_tail = 1'b1;
      end
      start = words_sent;
      while (words_sent - start < PhaseWords) send_frame();
    end
    in_valid_i <= 1'b0;

    while (due_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("hall_sensor_frame_decoder verification clean");
    end else begin
      $display("hall_sensor_frame_decoder verification failed");
    end
    $finish;
  end

  // Output side: hold stall in random bursts between free-running stretches.
  initial begin
    wait (rst_ni);
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!steady_tail) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string tag, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      fails++;
    end
  endtask

  // Check every accepted reading against the oldest one still due.
  always @(posedge clk_i) begin : reading_check
    flux_word_t want;
    flux_word_t got;
    if (rst_ni && out_fire) begin
      got = '{sensor_index_o, raw_x_o, raw_y_o, raw_z_o, field_x_o, field_y_o,
              field_z_o, frame_ok_o, group_ok_o, last_o};
      if (due_readings.size() == 0) begin
        $display("%0t: unexpected reading, sensor %0d raw %0d/%0d/%0d", $time,
                 got.sensor, got.rx, got.ry, got.rz);
        fails++;
      end else begin
        want = due_readings.pop_front();
        compare_field("sensor_index", want.sensor, got.sensor);
        compare_field("raw_x",        want.rx,     got.rx);
        compare_field("raw_y",        want.ry,     got.ry);
        compare_field("raw_z",        want.rz,     got.rz);
        compare_field("field_x",      want.fx,     got.fx);
        compare_field("field_y",      want.fy,     got.fy);
        compare_field("field_z",      want.fz,     got.fz);
        compare_field("frame_ok",     want.ok,     got.ok);
        compare_field("group_ok",     want.grp,    got.grp);
        compare_field("last",         want.last,   got.last);
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stuck_cycles <= (in_fire || out_fire || cfg_fire) ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles, %0d readings still due", $time,
                 stuck_cycles, due_readings.size());
        $display("hall_sensor_frame_decoder verification failed");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
src/hsfd_pkg.sv
src/hsfd_front.sv
src/hsfd_queue.sv
src/hsfd_back.sv
src/hall_sensor_frame_decoder.sv
tb/hall_sensor_frame_decoder_tb.sv
